[src/pce_pkg.sv]
`default_nettype none
package pce_pkg;

	typedef struct packed {
		logic valid;
		logic oor;
		logic zden;
	} pce_ctl_t;

	localparam logic [1:0] MODE_GRAY = 2'd0;
	localparam logic [1:0] MODE_JET  = 2'd1;
	localparam logic [1:0] MODE_HOT  = 2'd2;
	localparam logic [1:0] MODE_BONE = 2'd3;

	localparam logic [1:0] CFG_MAP_MODE = 2'd0;
	localparam logic [1:0] CFG_MAP_SIZE = 2'd1;
	localparam logic [1:0] CFG_REVERSE  = 2'd2;

	localparam int unsigned SIZE_W = 9;

endpackage
`default_nettype wire

[src/pce_div_cell.sv]
`default_nettype none
module pce_div_cell #(
	parameter int QW = 17
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pce_pkg::pce_ctl_t ctl_in,
	input  wire logic [8:0]        den_in,
	input  wire logic [8:0]        ra_in,
	input  wire logic [QW-1:0]     da_in,
	input  wire logic [QW-1:0]     qa_in,
	input  wire logic [8:0]        rb_in,
	input  wire logic [QW-1:0]     db_in,
	input  wire logic [QW-1:0]     qb_in,
	output pce_pkg::pce_ctl_t      ctl_q,
	output logic [8:0]             den_q,
	output logic [8:0]             ra_q,
	output logic [QW-1:0]          da_q,
	output logic [QW-1:0]          qa_q,
	output logic [8:0]             rb_q,
	output logic [QW-1:0]          db_q,
	output logic [QW-1:0]          qb_q
);
	import pce_pkg::*;

	logic [9:0] ta, tb;
	logic       gea, geb;

	// One restoring step per lane: bring down the next dividend bit.
	always_comb begin
		ta  = {ra_in, da_in[QW-1]};
		tb  = {rb_in, db_in[QW-1]};
		gea = ta >= {1'b0, den_in};
		geb = tb >= {1'b0, den_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		den_q <= den_in;
		ra_q  <= gea ? 9'(ta - {1'b0, den_in}) : ta[8:0];
		rb_q  <= geb ? 9'(tb - {1'b0, den_in}) : tb[8:0];
		da_q  <= da_in << 1;
		db_q  <= db_in << 1;
		qa_q  <= {qa_in[QW-2:0], gea};
		qb_q  <= {qb_in[QW-2:0], geb};
	end
endmodule
`default_nettype wire

[src/pce_color.sv]
`default_nettype none
module pce_color #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pce_pkg::pce_ctl_t  ctl_in,
	input  wire logic [FRAC_BITS:0] u_in,
	input  wire logic [FRAC_BITS:0] gray_in,
	input  wire logic [1:0]         mode,
	output logic                    done_q,
	output logic [7:0]              red_q,
	output logic [7:0]              green_q,
	output logic [7:0]              blue_q,
	output logic                    oor_q
);
	import pce_pkg::*;

	localparam int UW    = FRAC_BITS + 1;
	localparam int ONE_I = 1 << FRAC_BITS;
	localparam int K1_I  = ONE_I / 8;
	localparam int K3_I  = (3 * ONE_I) / 8;
	localparam int K5_I  = (5 * ONE_I) / 8;
	localparam int K7_I  = (7 * ONE_I) / 8;
	localparam int H2_I  = (3 * ONE_I) / 4;
	localparam int XW    = FRAC_BITS + 2;
	localparam int MUL3  = ((1 << (FRAC_BITS + 3)) + 2) / 3;
	localparam int PW    = 2 * XW;

	localparam logic [UW+2:0] ONE = (UW+3)'(ONE_I);

	function automatic logic [7:0] to_byte(input logic [UW+2:0] v);
		logic [UW+10:0] p;
		logic [UW+10:0] s;
		p = ({8'd0, v} << 8) - {8'd0, v};
		s = p >> FRAC_BITS;
		to_byte = (s > (UW+11)'(255)) ? 8'hFF : s[7:0];
	endfunction

	function automatic logic [7:0] bone(input logic [UW-1:0] u, input logic [7:0] h);
		logic [FRAC_BITS+12:0] p;
		p = (FRAC_BITS+13)'(u) * (FRAC_BITS+13)'(1785)
			+ ((FRAC_BITS+13)'(h) << FRAC_BITS);
		p = p >> (FRAC_BITS + 3);
		bone = (p > (FRAC_BITS+13)'(255)) ? 8'hFF : p[7:0];
	endfunction

	// First stage: the hot ramp needs a divide by three, done by reciprocal.
	logic [XW-1:0] x;
	logic [PW-1:0] prod;
	always_comb begin
		if (u_in <= UW'(K3_I)) begin
			x = XW'({u_in, 3'b000});
		end else if (u_in <= UW'(H2_I)) begin
			x = XW'({UW'(u_in - UW'(K3_I)), 3'b000});
		end else begin
			x = '0;
		end
		prod = PW'(x) * PW'(MUL3);
	end

	pce_ctl_t      ctl_s1;
	logic [UW-1:0] u_s1, gray_s1, hm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		u_s1    <= u_in;
		gray_s1 <= gray_in;
		hm_s1   <= UW'(prod >> (FRAC_BITS + 3));
	end

	logic [UW+2:0] u3, m, jr, jg, jb, hr, hg, hb;
	logic [7:0]    r_n, g_n, b_n, hrb, hgb, hbb, gb;

	always_comb begin
		u3 = (UW+3)'(u_s1);
		jr = '0;
		jg = '0;
		jb = '0;
		m  = '0;
		if (u3 <= (UW+3)'(K1_I)) begin
			m  = u3 << 3;
			jb = (m + ONE) >> 1;
		end else if (u3 <= (UW+3)'(K3_I)) begin
			m  = (u3 - (UW+3)'(K1_I)) << 2;
			jg = m;
			jb = ONE;
		end else if (u3 <= (UW+3)'(K5_I)) begin
			m  = (u3 - (UW+3)'(K3_I)) << 2;
			jr = m;
			jg = ONE;
			jb = ONE - m;
		end else if (u3 <= (UW+3)'(K7_I)) begin
			m  = (u3 - (UW+3)'(K5_I)) << 2;
			jr = ONE;
			jg = ONE - m;
		end else begin
			m  = (u3 - (UW+3)'(K7_I)) << 3;
			if (m > ONE) m = ONE;
			jr = ((ONE << 1) - m) >> 1;
		end

		hr = '0;
		hg = '0;
		hb = '0;
		if (u3 <= (UW+3)'(K3_I)) begin
			hr = (UW+3)'(hm_s1);
		end else if (u3 <= (UW+3)'(H2_I)) begin
			hr = ONE;
			hg = (UW+3)'(hm_s1);
		end else begin
			hr = ONE;
			hg = ONE;
			hb = (u3 - (UW+3)'(H2_I)) << 2;
		end
		hrb = to_byte(hr);
		hgb = to_byte(hg);
		hbb = to_byte(hb);

		gb = ctl_s1.zden ? 8'd0
			: ((gray_s1 > UW'(255)) ? 8'hFF : gray_s1[7:0]);

		case (mode)
			MODE_GRAY: begin
				r_n = gb;
				g_n = gb;
				b_n = gb;
			end
			MODE_JET: begin
				r_n = to_byte(jr);
				g_n = to_byte(jg);
				b_n = to_byte(jb);
			end
			MODE_HOT: begin
				r_n = hrb;
				g_n = hgb;
				b_n = hbb;
			end
			default: begin
				r_n = bone(u_s1, hbb);
				g_n = bone(u_s1, hgb);
				b_n = bone(u_s1, hrb);
			end
		endcase
		if (ctl_s1.oor) begin
			r_n = '0;
			g_n = '0;
			b_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		red_q   <= r_n;
		green_q <= g_n;
		blue_q  <= b_n;
		oor_q   <= ctl_s1.oor;
	end
endmodule
`default_nettype wire

[src/procedural_colormap_entry.sv]
`default_nettype none
// Channel  | Signals                                   | Handshake
// command  | start, busy, entry_index                  | taken when start && !busy
// result   | done, red, green, blue, out_of_range      | one-cycle strobe on done
// config   | cfg_we, cfg_index, cfg_data               | written when cfg_we
//
// One index is taken every cycle; busy is never raised.
// The pipeline is FRAC_BITS + 1 divider cells, each settling one quotient bit
// of the position and of the gray level, then two color stages.
// Reset clears the pipeline valid bits and loads the register defaults.
// The result side cannot stall, so nothing is ever held back.
module procedural_colormap_entry #(
	parameter int MAX_ENTRIES = 256,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] entry_index,
	output logic            done,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue,
	output logic            out_of_range,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data
);
	import pce_pkg::*;

	localparam int QW = FRAC_BITS + 1;
	localparam int BW = QW + 9;

	logic [1:0]        map_mode_q;
	logic [SIZE_W-1:0] map_size_q;
	logic              reverse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_mode_q <= MODE_GRAY;
			map_size_q <= SIZE_W'(256);
			reverse_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_MODE: map_mode_q <= cfg_data[1:0];
				CFG_MAP_SIZE: map_size_q <= cfg_data;
				CFG_REVERSE:  reverse_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic [SIZE_W-1:0] sz, den, j;
	logic [BW-1:0]     bdiv;
	pce_ctl_t          ctl0;

	always_comb begin
		if (32'(map_size_q) > 32'(MAX_ENTRIES)) sz = SIZE_W'(MAX_ENTRIES);
		else sz = map_size_q;
		den = sz - 9'd1;
		j   = reverse_q ? 9'(den - {1'b0, entry_index}) : {1'b0, entry_index};
		bdiv = (BW'(j) << 8) - BW'(j);
		ctl0.valid = start;
		ctl0.oor   = {1'b0, entry_index} >= sz;
		ctl0.zden  = den == '0;
	end

	pce_ctl_t        ctl_c [QW+1];
	logic [8:0]      den_c [QW+1];
	logic [8:0]      ra_c  [QW+1];
	logic [8:0]      rb_c  [QW+1];
	logic [QW-1:0]   da_c  [QW+1];
	logic [QW-1:0]   db_c  [QW+1];
	logic [QW-1:0]   qa_c  [QW+1];
	logic [QW-1:0]   qb_c  [QW+1];

	// Position dividend is j << FRAC_BITS, gray dividend is 255 * j.
	assign ctl_c[0] = ctl0;
	assign den_c[0] = den;
	assign ra_c[0]  = {1'b0, j[8:1]};
	assign da_c[0]  = {j[0], {(QW-1){1'b0}}};
	assign qa_c[0]  = '0;
	assign rb_c[0]  = 9'(bdiv >> QW);
	assign db_c[0]  = bdiv[QW-1:0];
	assign qb_c[0]  = '0;

	for (genvar k = 0; k < QW; k++) begin : g_cell
		pce_div_cell #(.QW(QW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_c[k]),
			.den_in (den_c[k]),
			.ra_in  (ra_c[k]),
			.da_in  (da_c[k]),
			.qa_in  (qa_c[k]),
			.rb_in  (rb_c[k]),
			.db_in  (db_c[k]),
			.qb_in  (qb_c[k]),
			.ctl_q  (ctl_c[k+1]),
			.den_q  (den_c[k+1]),
			.ra_q   (ra_c[k+1]),
			.da_q   (da_c[k+1]),
			.qa_q   (qa_c[k+1]),
			.rb_q   (rb_c[k+1]),
			.db_q   (db_c[k+1]),
			.qb_q   (qb_c[k+1])
		);
	end

	logic [QW-1:0] u_fin;
	assign u_fin = ctl_c[QW].zden ? '0 : qa_c[QW];

	pce_color #(.FRAC_BITS(FRAC_BITS)) u_color (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_c[QW]),
		.u_in    (u_fin),
		.gray_in (qb_c[QW]),
		.mode    (map_mode_q),
		.done_q  (done),
		.red_q   (red),
		.green_q (green),
		.blue_q  (blue),
		.oor_q   (out_of_range)
	);
endmodule
`default_nettype wire

[src/pce_checker.sv]
`default_nettype none
module pce_checker #(
	parameter int MAX_ENTRIES = 256,
	parameter int FRAC_BITS   = 16
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [7:0] entry_index,
	input wire logic       done,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue,
	input wire logic       out_of_range,
	input wire logic       cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [8:0] cfg_data
);
	localparam int LAT = FRAC_BITS + 3;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_oor_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("out-of-range beat carries color");

	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without a command");

	a_big_index_oor: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_range && (MAX_ENTRIES < 256) |->
		$past(entry_index, LAT) <= 8'(MAX_ENTRIES - 1))
		else $error("index past the map limit reported in range");
endmodule

bind procedural_colormap_entry pce_checker #(
	.MAX_ENTRIES(MAX_ENTRIES),
	.FRAC_BITS(FRAC_BITS)
) u_pce_checker (.*);
`default_nettype wire
